### hdl/cky_pkg.sv
// Shared types, constants and address helpers for the CKY tree decoder.
package cky_pkg;

    localparam int MAX_WORDS  = 32;
    localparam int MAX_LABELS = 16;
    localparam int STACK_DEPTH = MAX_WORDS + 1;

    localparam int LABEL_W = 4;
    localparam int LEFT_W  = 5;
    localparam int RIGHT_W = 6;
    localparam int POT_W   = 32;
    localparam int SCORE_W = 40;
    localparam int NLAB_W  = 5;

    localparam int SPAN_AW = 2 * LEFT_W;
    localparam int POT_AW  = LABEL_W + SPAN_AW;

    localparam int REG_SENTENCE_LENGTH = 0;
    localparam int REG_LABEL_COUNT     = 1;

    // One chart span: best label score, its label and the best split point
    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic [LABEL_W-1:0]        label;
        logic [RIGHT_W-1:0]        split;
    } span_entry_t;

    // One backtrack stack slot
    typedef struct packed {
        logic               valid;
        logic [LABEL_W-1:0] label;
        logic [LEFT_W-1:0]  left;
        logic [RIGHT_W-1:0] right;
    } stack_slot_t;

    typedef enum logic [1:0] {
        STK_HOLD,
        STK_LOAD,
        STK_PUSH,
        STK_POP
    } stack_op_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SPAN,
        ST_SPLIT,
        ST_LABEL,
        ST_WRITE,
        ST_EM_INIT,
        ST_EM_RD,
        ST_EM_K,
        ST_EM_T,
        ST_EM_PUSH
    } state_t;

    // Right boundary is stored as right-1 so that both ends fit five bits
    function automatic logic [SPAN_AW-1:0] span_addr(input logic [LEFT_W-1:0] i,
                                                     input logic [RIGHT_W-1:0] j);
        logic [RIGHT_W-1:0] jm1;
        jm1 = j - RIGHT_W'(1);
        return {i, jm1[LEFT_W-1:0]};
    endfunction

    function automatic logic [POT_AW-1:0] pot_addr(input logic [LABEL_W-1:0] l,
                                                   input logic [LEFT_W-1:0] i,
                                                   input logic [RIGHT_W-1:0] j);
        return {l, span_addr(i, j)};
    endfunction

endpackage

### hdl/cky_stack_cell.sv
// One slot of the shift-register backtrack stack.
module cky_stack_cell import cky_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  stack_op_t   op,
    input  stack_slot_t up_in,
    input  stack_slot_t down_in,
    output stack_slot_t slot
);

    logic        valid_reg;
    stack_slot_t data_reg;

    // Take the neighbor above on push or load, the one below on pop
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            case (op)
                STK_LOAD, STK_PUSH: valid_reg <= up_in.valid;
                STK_POP:            valid_reg <= down_in.valid;
                default:            valid_reg <= valid_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (op)
            STK_LOAD, STK_PUSH: data_reg <= up_in;
            STK_POP:            data_reg <= down_in;
            default:            data_reg <= data_reg;
        endcase
    end

    always_comb begin
        slot       = data_reg;
        slot.valid = valid_reg;
    end

endmodule

### hdl/cky_stack.sv
// Backtrack stack built as a chain of slot cells; the top is slot 0.
module cky_stack import cky_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  stack_op_t   op,
    input  stack_slot_t din,
    output stack_slot_t top,
    output logic        second_valid
);

    stack_slot_t slots [STACK_DEPTH];
    stack_slot_t empty_slot;

    assign empty_slot = '0;

    genvar g;
    generate
        for (g = 0; g < STACK_DEPTH; g++) begin : g_cell
            stack_op_t   cell_op;
            stack_slot_t up_in;
            stack_slot_t down_in;

            // Load touches the top slot only
            assign cell_op = (op == STK_LOAD && g != 0) ? STK_HOLD : op;
            if (g == 0) begin : g_top
                assign up_in = din;
            end else begin : g_mid
                assign up_in = slots[g-1];
            end
            if (g == STACK_DEPTH - 1) begin : g_bot
                assign down_in = empty_slot;
            end else begin : g_up
                assign down_in = slots[g+1];
            end

            cky_stack_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .op      (cell_op),
                .up_in   (up_in),
                .down_in (down_in),
                .slot    (slots[g])
            );
        end
    endgenerate

    assign top          = slots[0];
    assign second_valid = slots[1].valid;

endmodule

### hdl/cky_viterbi_tree_decoder.sv
// Top level of the CKY Viterbi decoder for labeled binary trees.
//
//  channel | direction | handshake            | content
//  s_      | in        | s_tvalid / s_tready  | span score, tlast starts decoding
//  m_      | out       | m_tvalid / m_tready  | tree nodes in preorder, tlast on final
//  cfg_    | in        | cfg_wr_en            | sentence_length, label_count
//
// Score items load one per cycle while in the load state. After the last one the chart fill
// issues one read per cycle (a pair of span reads in the split pass): a span of s words has
// a setup step, a split pass when s > 1, a label pass over the saturated label_count and a
// write. Emission has a start step, then a span read, a child read and an output step for
// each node, plus a push step for each inner node. Reset is synchronous; memories are not
// cleared. A stalled result holds in the output register and only blocks the next tree node.
module cky_viterbi_tree_decoder import cky_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [5:0]  cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // pot_label[3:0], pot_left[8:4], pot_right[14:9], pot_score[46:15], zero[47]
    input  logic [47:0] s_tdata,
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    // node_label[3:0], node_left[8:4], node_right[14:9], tree_score[54:15], zero[55]
    output logic [55:0] m_tdata,
    output logic        m_tlast
);

    state_t state_reg, state_next;

    logic [5:0] sentence_length_reg;
    logic [4:0] label_count_reg;
    logic [RIGHT_W-1:0] n_reg;
    logic [NLAB_W-1:0]  nlab_reg;

    logic [RIGHT_W-1:0] s_reg;
    logic [LEFT_W-1:0]  i_reg;
    logic [RIGHT_W-1:0] j;
    logic [RIGHT_W-1:0] iss_reg;
    logic               issue;

    logic               rd_v_reg, sum_v_reg, first_reg;
    logic [RIGHT_W-1:0] rd_idx_reg, sum_idx_reg;
    logic signed [SCORE_W-1:0] sum_reg, best_split_reg, max_reg, root_reg;
    logic [RIGHT_W-1:0] best_k_reg;
    logic [LABEL_W-1:0] max_t_reg;
    logic [RIGHT_W-1:0] em_k_reg;
    logic [LEFT_W-1:0]  em_left_reg;

    logic [LABEL_W-1:0] in_label;
    logic [LEFT_W-1:0]  in_left;
    logic [RIGHT_W-1:0] in_right;
    logic signed [POT_W-1:0] in_score;
    logic               s_fire, in_ok;

    logic signed [POT_W-1:0] pot_mem [2**POT_AW];
    logic signed [POT_W-1:0] pot_q;
    span_entry_t span_mem [2**SPAN_AW];
    span_entry_t span_a_q, span_b_q;
    logic              rd_a_en, rd_b_en, rd_p_en;
    logic [SPAN_AW-1:0] rd_a_addr, rd_b_addr;

    stack_op_t   stk_op;
    stack_slot_t stk_din, stk_top;
    logic        stk_second;
    logic        out_free, leaf;

    logic        m_valid_reg, m_last_reg;
    logic [LABEL_W-1:0] m_label_reg;
    logic [LEFT_W-1:0]  m_left_reg;
    logic [RIGHT_W-1:0] m_right_reg;
    logic signed [SCORE_W-1:0] m_score_reg;

    assign in_label = s_tdata[3:0];
    assign in_left  = s_tdata[8:4];
    assign in_right = s_tdata[14:9];
    assign in_score = s_tdata[46:15];
    assign s_tready = (state_reg == ST_LOAD);
    assign s_fire   = s_tvalid && s_tready;
    assign in_ok    = (in_right <= RIGHT_W'(MAX_WORDS)) && (RIGHT_W'(in_left) < in_right);

    assign j        = RIGHT_W'(i_reg) + s_reg;
    assign out_free = !m_valid_reg || m_tready;
    assign leaf     = (stk_top.right == RIGHT_W'(stk_top.left) + RIGHT_W'(1));

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sentence_length_reg <= 6'd1;
            label_count_reg     <= 5'd1;
        end else if (cfg_wr_en) begin
            if (cfg_addr == 1'(REG_SENTENCE_LENGTH)) sentence_length_reg <= cfg_wr_data;
            else                                    label_count_reg <= cfg_wr_data[4:0];
        end
    end

    // Issue one read per cycle while the current pass has work left
    always_comb begin
        issue = 1'b0;
        if (state_reg == ST_SPLIT) issue = (iss_reg < j);
        if (state_reg == ST_LABEL) issue = (iss_reg < RIGHT_W'(nlab_reg));
    end

    // Memory read port selection
    always_comb begin
        rd_a_en   = 1'b0;
        rd_b_en   = 1'b0;
        rd_p_en   = 1'b0;
        rd_a_addr = span_addr(i_reg, iss_reg);
        rd_b_addr = span_addr(iss_reg[LEFT_W-1:0], j);
        case (state_reg)
            ST_SPLIT: begin
                rd_a_en = issue;
                rd_b_en = issue;
            end
            ST_LABEL: rd_p_en = issue;
            ST_EM_RD: begin
                rd_a_en   = 1'b1;
                rd_a_addr = span_addr(stk_top.left, stk_top.right);
            end
            ST_EM_K: begin
                rd_a_en   = 1'b1;
                rd_b_en   = 1'b1;
                rd_a_addr = span_addr(stk_top.left, span_a_q.split);
                rd_b_addr = span_addr(span_a_q.split[LEFT_W-1:0], stk_top.right);
            end
            default: ;
        endcase
    end

    // Potential store: one write port on load, one read port for the label pass
    always_ff @(posedge aclk) begin
        if (s_fire && in_ok) pot_mem[pot_addr(in_label, in_left, in_right)] <= in_score;
        if (rd_p_en) pot_q <= pot_mem[pot_addr(iss_reg[LABEL_W-1:0], i_reg, j)];
    end

    // Span chart: one write port, two read ports
    always_ff @(posedge aclk) begin
        if (state_reg == ST_WRITE) begin
            span_mem[span_addr(i_reg, j)] <= '{score: max_reg, label: max_t_reg,
                                               split: best_k_reg};
        end
        if (rd_a_en) span_a_q <= span_mem[rd_a_addr];
        if (rd_b_en) span_b_q <= span_mem[rd_b_addr];
    end

    // Next state, stack control
    always_comb begin
        state_next = state_reg;
        stk_op     = STK_HOLD;
        stk_din    = '0;
        case (state_reg)
            ST_LOAD:  if (s_fire && s_tlast) state_next = ST_SPAN;
            ST_SPAN:  state_next = (s_reg == RIGHT_W'(1)) ? ST_LABEL : ST_SPLIT;
            ST_SPLIT: if (!issue && !rd_v_reg && !sum_v_reg) state_next = ST_LABEL;
            ST_LABEL: if (!issue && !rd_v_reg && !sum_v_reg) state_next = ST_WRITE;
            ST_WRITE: begin
                if (j == n_reg && s_reg == n_reg) state_next = ST_EM_INIT;
                else                              state_next = ST_SPAN;
            end
            ST_EM_INIT: begin
                stk_op     = STK_PUSH;
                stk_din    = '{valid: 1'b1, label: '0, left: '0, right: n_reg};
                state_next = ST_EM_RD;
            end
            ST_EM_RD: state_next = ST_EM_K;
            ST_EM_K:  state_next = ST_EM_T;
            ST_EM_T: begin
                if (out_free) begin
                    if (leaf) begin
                        stk_op     = STK_POP;
                        state_next = stk_second ? ST_EM_RD : ST_LOAD;
                    end else begin
                        stk_op     = STK_LOAD;
                        stk_din    = '{valid: 1'b1, label: span_b_q.label,
                                       left: em_k_reg[LEFT_W-1:0], right: stk_top.right};
                        state_next = ST_EM_PUSH;
                    end
                end
            end
            ST_EM_PUSH: begin
                stk_op     = STK_PUSH;
                stk_din    = '{valid: 1'b1, label: span_a_q.label,
                               left: em_left_reg, right: em_k_reg};
                state_next = ST_EM_RD;
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_LOAD;
        else          state_reg <= state_next;
    end

    // Pipeline valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_v_reg  <= 1'b0;
            sum_v_reg <= 1'b0;
        end else begin
            rd_v_reg  <= issue;
            sum_v_reg <= rd_v_reg;
        end
    end

    // Chart fill datapath: counters, add stage, compare stage
    always_ff @(posedge aclk) begin
        rd_idx_reg  <= iss_reg;
        sum_idx_reg <= rd_idx_reg;
        if (state_reg == ST_SPLIT) sum_reg <= span_a_q.score + span_b_q.score;
        else                       sum_reg <= SCORE_W'(pot_q) + best_split_reg;
        if (issue) iss_reg <= iss_reg + RIGHT_W'(1);

        case (state_reg)
            ST_LOAD: begin
                s_reg <= RIGHT_W'(1);
                i_reg <= '0;
                if (sentence_length_reg == 6'd0)                n_reg <= RIGHT_W'(1);
                else if (sentence_length_reg > 6'(MAX_WORDS))   n_reg <= RIGHT_W'(MAX_WORDS);
                else                                            n_reg <= sentence_length_reg;
                if (label_count_reg == 5'd0)                    nlab_reg <= NLAB_W'(1);
                else if (label_count_reg > 5'(MAX_LABELS))      nlab_reg <= NLAB_W'(MAX_LABELS);
                else                                            nlab_reg <= label_count_reg;
            end
            ST_SPAN: begin
                first_reg      <= 1'b1;
                best_split_reg <= '0;
                best_k_reg     <= '0;
                if (s_reg == RIGHT_W'(1)) iss_reg <= '0;
                else                      iss_reg <= RIGHT_W'(i_reg) + RIGHT_W'(1);
            end
            ST_SPLIT: begin
                if (sum_v_reg && (first_reg || sum_reg > best_split_reg)) begin
                    best_split_reg <= sum_reg;
                    best_k_reg     <= sum_idx_reg;
                end
                if (sum_v_reg) first_reg <= 1'b0;
                if (!issue && !rd_v_reg && !sum_v_reg) begin
                    iss_reg   <= '0;
                    first_reg <= 1'b1;
                end
            end
            ST_LABEL: begin
                if (sum_v_reg && (first_reg || sum_reg > max_reg)) begin
                    max_reg   <= sum_reg;
                    max_t_reg <= sum_idx_reg[LABEL_W-1:0];
                end
                if (sum_v_reg) first_reg <= 1'b0;
                if (sum_v_reg && sum_idx_reg == '0 && i_reg == '0 && j == n_reg)
                    root_reg <= sum_reg;
            end
            ST_WRITE: begin
                if (j == n_reg) begin
                    i_reg <= '0;
                    s_reg <= s_reg + RIGHT_W'(1);
                end else begin
                    i_reg <= i_reg + LEFT_W'(1);
                end
            end
            // Keep the split and the parent's left boundary for the child pushes
            ST_EM_K: begin
                em_k_reg    <= span_a_q.split;
                em_left_reg <= stk_top.left;
            end
            default: ;
        endcase
    end

    cky_stack u_stack (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .op           (stk_op),
        .din          (stk_din),
        .top          (stk_top),
        .second_valid (stk_second)
    );

    // Output register: load a node when free, drop it after the transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_EM_T && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_EM_T && out_free) begin
            m_label_reg <= stk_top.label;
            m_left_reg  <= stk_top.left;
            m_right_reg <= stk_top.right;
            m_score_reg <= root_reg;
            m_last_reg  <= leaf && !stk_second;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {1'b0, m_score_reg, m_right_reg, m_left_reg, m_label_reg};

    // The stack is drained whenever score items are taken
    a_stack_empty_on_load: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_LOAD |-> !stk_top.valid)
        else $error("backtrack stack not empty while loading");

    // An emitted node always comes from a live stack slot
    a_emit_from_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EM_T || state_reg == ST_EM_PUSH) |-> stk_top.valid)
        else $error("node emitted from empty stack");

    // The split search never runs past the right boundary
    a_split_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SPLIT |-> iss_reg <= j)
        else $error("split index beyond span");

endmodule

### tb/cky_viterbi_tree_decoder_tb.sv
// Self-checking testbench for the CKY Viterbi tree decoder: random score frames against a chart predictor.
`timescale 1ns / 100ps

module cky_viterbi_tree_decoder_tb;
    import cky_pkg::*;

    localparam int QUIET_LIMIT = 400000;
    localparam int SETTLE      = 40;

    typedef struct {
        logic [LABEL_W-1:0]        label;
        logic [LEFT_W-1:0]         left;
        logic [RIGHT_W-1:0]        right;
        logic signed [POT_W-1:0]   score;
        logic                      last;
    } span_item_t;

    typedef struct {
        logic [LABEL_W-1:0]        label;
        logic [LEFT_W-1:0]         left;
        logic [RIGHT_W-1:0]        right;
        logic signed [SCORE_W-1:0] score;
        logic                      last;
    } tree_node_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_addr = 1'b0;
    logic [5:0]  cfg_wr_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic        m_tlast;

    span_item_t pending_spans[$];
    tree_node_t expected_nodes[$];
    span_item_t cur_span;
    int         fail_count = 0;
    int         quiet_cycles = 0;
    int         sent_items = 0;
    bit         no_idle = 1'b0;

    // Predictor state
    logic signed [SCORE_W-1:0] pot_mem  [MAX_LABELS][MAX_WORDS+1][MAX_WORDS+1];
    logic signed [SCORE_W-1:0] chart_mem[MAX_LABELS][MAX_WORDS+1][MAX_WORDS+1];
    int                        bp_k [MAX_LABELS][MAX_WORDS+1][MAX_WORDS+1];
    int                        bp_l [MAX_LABELS][MAX_WORDS+1][MAX_WORDS+1];
    int                        bp_r [MAX_LABELS][MAX_WORDS+1][MAX_WORDS+1];
    logic [5:0]                len_reg = 6'd1;
    logic [4:0]                lab_reg = 5'd1;
    // Spans already loaded, tracked on the stimulus side
    bit                        loaded[MAX_LABELS][MAX_WORDS+1][MAX_WORDS+1];

    cky_viterbi_tree_decoder dut (.*);

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic int clamp_to(int v, int hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int best_label(int nlab, int a, int b);
        int best;
        best = 0;
        for (int c = 1; c < nlab; c++)
            if (chart_mem[c][a][b] > chart_mem[best][a][b]) best = c;
        return best;
    endfunction

    // Fill the chart bottom-up and queue the preorder walk of the root tree
    function automatic void decode_tree();
        int n, nlab, j, cl, cr, top, nl, na, nb, k;
        logic signed [SCORE_W-1:0] v, best;
        int stk_l[$], stk_a[$], stk_b[$];
        tree_node_t node;
        n = clamp_to(int'(len_reg), MAX_WORDS);
        nlab = clamp_to(int'(lab_reg), MAX_LABELS);
        for (int s = 1; s <= n; s++) begin
            for (int i = 0; i + s <= n; i++) begin
                j = i + s;
                for (int l = 0; l < nlab; l++) begin
                    if (s == 1) begin
                        chart_mem[l][i][j] = pot_mem[l][i][j];
                        bp_k[l][i][j] = 0; bp_l[l][i][j] = 0; bp_r[l][i][j] = 0;
                    end else begin
                        best = '0;
                        for (int kk = i + 1; kk < j; kk++) begin
                            cl = best_label(nlab, i, kk);
                            cr = best_label(nlab, kk, j);
                            v = pot_mem[l][i][j] + chart_mem[cl][i][kk] + chart_mem[cr][kk][j];
                            if (kk == i + 1 || v > best) begin
                                best = v; bp_k[l][i][j] = kk;
                                bp_l[l][i][j] = cl; bp_r[l][i][j] = cr;
                            end
                        end
                        chart_mem[l][i][j] = best;
                    end
                end
            end
        end
        nl = 0; na = 0; nb = n;
        stk_l = {stk_l, nl}; stk_a = {stk_a, na}; stk_b = {stk_b, nb};
        while (stk_l.size() > 0) begin
            nl = stk_l.pop_back(); na = stk_a.pop_back(); nb = stk_b.pop_back();
            node.label = LABEL_W'(nl); node.left = LEFT_W'(na); node.right = RIGHT_W'(nb);
            node.score = chart_mem[0][0][n];
            node.last = (stk_l.size() == 0) && (nb <= na + 1);
            expected_nodes = {expected_nodes, node};
            if (nb > na + 1) begin
                k = bp_k[nl][na][nb];
                stk_l = {stk_l, bp_r[nl][na][nb]}; stk_a = {stk_a, k}; stk_b = {stk_b, nb};
                stk_l = {stk_l, bp_l[nl][na][nb]}; stk_a = {stk_a, na}; stk_b = {stk_b, k};
            end
        end
    endfunction

    function automatic void absorb_span(span_item_t it);
        if (it.right <= MAX_WORDS && it.left < it.right)
            pot_mem[it.label][it.left][it.right] = SCORE_W'(it.score);
        if (it.last) decode_tree();
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // Reset, then stream queued spans with random idling
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) absorb_span(cur_span);
            if (!s_tvalid || s_tready) begin
                if (pending_spans.size() > 0 && (no_idle || $urandom_range(99) >= 10)) begin
                    cur_span = pending_spans.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {1'b0, cur_span.score, cur_span.right, cur_span.left,
                                 cur_span.label};
                    s_tlast  <= cur_span.last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Check each node transfer against the oldest expectation
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= no_idle || ($urandom_range(99) >= 10);
            if (m_tvalid && m_tready) begin
                if (expected_nodes.size() == 0) begin
                    report_mismatch("unexpected node", 64'(m_tdata), 64'd0);
                end else begin
                    tree_node_t e;
                    e = expected_nodes.pop_front();
                    if (m_tdata[3:0] !== e.label)
                        report_mismatch("label", 64'(m_tdata[3:0]), 64'(e.label));
                    if (m_tdata[8:4] !== e.left)
                        report_mismatch("left", 64'(m_tdata[8:4]), 64'(e.left));
                    if (m_tdata[14:9] !== e.right)
                        report_mismatch("right", 64'(m_tdata[14:9]), 64'(e.right));
                    if (m_tdata[54:15] !== e.score)
                        report_mismatch("score", 64'(m_tdata[54:15]),
                                        64'(e.score[SCORE_W-1:0]));
                    if (m_tlast !== e.last)
                        report_mismatch("last", 64'(m_tlast), 64'(e.last));
                end
            end
        end
    end

    // Watchdog on cycles without any transfer or register write
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(int idx, logic [5:0] val);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx[0];
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_SENTENCE_LENGTH) len_reg = val;
        else lab_reg = val[4:0];
    endtask

    function automatic logic [31:0] pick_score(int mode, logic [31:0] fixed);
        if (mode) return fixed;
        case ($urandom_range(7))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'h0;
            default: return $urandom;
        endcase
    endfunction

    // One parse: set registers, load missing (in constant mode all) and random spans, decode, drain
    task automatic run_sentence(logic [5:0] len_v, logic [5:0] lab_v, int nrand,
                                int const_mode, logic [31:0] fixed);
        int n, nl, r, a;
        span_item_t it;
        n = clamp_to(int'(len_v), MAX_WORDS);
        nl = clamp_to(int'(lab_v[4:0]), MAX_LABELS);
        write_reg(REG_SENTENCE_LENGTH, len_v);
        write_reg(REG_LABEL_COUNT, lab_v);
        for (int l = 0; l < nl; l++)
            for (int i = 0; i < n; i++)
                for (int j = i + 1; j <= n; j++)
                    if (!loaded[l][i][j] || const_mode) begin
                        it.label = LABEL_W'(l); it.left = LEFT_W'(i); it.right = RIGHT_W'(j);
                        it.last = 1'b0;
                        it.score = pick_score(const_mode, fixed);
                        loaded[l][i][j] = 1'b1;
                        pending_spans = {pending_spans, it};
                        sent_items++;
                    end
        for (int c = 0; c <= nrand; c++) begin
            r = $urandom_range(9);
            it.score = pick_score(const_mode, fixed);
            it.last = (c == nrand);
            if (r < 6) begin
                a = $urandom_range(n - 1);
                it.left = LEFT_W'(a); it.right = RIGHT_W'($urandom_range(n, a + 1));
                it.label = LABEL_W'($urandom_range(nl - 1));
            end else if (r < 8) begin
                a = $urandom_range(31);
                it.left = LEFT_W'(a); it.right = RIGHT_W'($urandom_range(32, a + 1));
                it.label = LABEL_W'($urandom);
            end else begin
                it.label = LABEL_W'($urandom); it.left = LEFT_W'($urandom);
                it.right = (r == 8) ? RIGHT_W'($urandom_range(63, 33))
                                    : RIGHT_W'($urandom_range(int'(it.left)));
            end
            if (it.right <= MAX_WORDS && it.left < it.right)
                loaded[it.label][it.left][it.right] = 1'b1;
            pending_spans = {pending_spans, it};
            sent_items++;
        end
        while (pending_spans.size() > 0 || s_tvalid) @(posedge aclk);
        while (expected_nodes.size() > 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        // Directed: register saturation, a no-idle stretch, ties and score edges
        run_sentence(6'd1, 6'd1, 1, 0, 0);
        no_idle = 1'b1;
        run_sentence(6'd4, 6'd3, 3, 0, 0);
        no_idle = 1'b0;
        run_sentence(6'd1, 6'd31, 2, 0, 0);
        run_sentence(6'd0, 6'd0, 2, 0, 0);
        run_sentence(6'd3, 6'd2, 2, 1, 32'h0);
        run_sentence(6'd2, 6'd2, 1, 1, 32'h7fffffff);
        run_sentence(6'd2, 6'd2, 1, 1, 32'h80000000);
        // Random short sentences
        while (sent_items < 100) begin
            int nr;
            nr = $urandom_range(6, 2);
            no_idle = ($urandom_range(7) == 0);
            run_sentence(6'($urandom_range(4, 1)), 6'($urandom_range(3, 1)), nr, 0, 0);
        end
        repeat (SETTLE) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

### filelist.f
hdl/cky_pkg.sv
hdl/cky_stack_cell.sv
hdl/cky_stack.sv
hdl/cky_viterbi_tree_decoder.sv
tb/cky_viterbi_tree_decoder_tb.sv
